// ===== rtl/core/bh_pkg.sv =====
// Shared types, codes and the key-order function for the binary heap core.
// Used by bh_level_cell and binary_heap_insert_delete_core; depends on nothing.
package bh_pkg;

	localparam int KEY_W = 32;
	// Level number and level offset widths; they fit heaps of up to 8191 entries.
	localparam int LVL_W = 4;
	localparam int OFF_W = 12;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_DELETE = 1'b1;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;

	// One request per cycle, seen by every level cell.
	typedef struct packed {
		logic             rd_en;
		logic [LVL_W-1:0] rd_lvl;
		logic [OFF_W-1:0] rd_off_a;
		logic [OFF_W-1:0] rd_off_b;
		logic             wr_en;
		logic [LVL_W-1:0] wr_lvl;
		logic [OFF_W-1:0] wr_off;
		logic [KEY_W-1:0] wr_key;
	} bh_req_t;

	// Read data handed from cell to cell toward the root.
	typedef struct packed {
		logic [KEY_W-1:0] a;
		logic [KEY_W-1:0] b;
	} bh_rd_t;

	// True when key a belongs above key b under the current ordering.
	function automatic logic bh_above(input logic signed [KEY_W-1:0] a,
		input logic signed [KEY_W-1:0] b, input logic min_mode);
		return min_mode ? (a < b) : (a > b);
	endfunction

endpackage

// ===== rtl/core/binary_heap_insert_delete_core.sv =====
// Binary heap priority queue of signed 32-bit keys, as a chain of per-level cells and a sequencer.
// Uses bh_pkg and instantiates one bh_level_cell per heap level.
//
// The heap keeps up to HEAP_DEPTH signed keys, smallest at the root when min_mode is 1 and
// largest when it is 0. Each input word is an insert or a delete command and gives exactly one
// result word with status, root and entry count. Items are handled one at a time; the next one
// is taken while the previous result still waits on the output. Every sift step is one read
// of a level cell followed by one compare and write, and an insert climbs one level per step.
// A delete first scans the stored entries in array order at one entry per cycle, then, unless
// the match is the last entry, loads the last entry (S_DEL_RD, S_DEL_LD) and sifts it up and
// down. No clearing pass is needed after reset.
module binary_heap_insert_delete_core import bh_pkg::*; #(
	parameter int HEAP_DEPTH = 64
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_wr_en,
	input  logic                    cfg_wr_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    command,
	input  logic signed [KEY_W-1:0] key_value,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [1:0]              status,
	output logic                    root_valid,
	output logic signed [KEY_W-1:0] root_value,
	output logic [6:0]              entry_count
);

	localparam int LEVELS = $clog2(HEAP_DEPTH + 1);
	localparam int CW     = LEVELS;
	localparam int OFFW   = (LEVELS > 1) ? LEVELS - 1 : 1;
	localparam int LVW    = $clog2(LEVELS + 1);

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_SCAN   = 9'b000000010,
		S_DEL_RD = 9'b000000100,
		S_DEL_LD = 9'b000001000,
		S_UP     = 9'b000010000,
		S_UP_CMP = 9'b000100000,
		S_DN     = 9'b001000000,
		S_DN_CMP = 9'b010000000,
		S_FIN    = 9'b100000000
	} state_t;

	state_t state_q, state_d;

	logic             min_mode_q;
	logic             del_q, del_d;
	logic [KEY_W-1:0] key_q, key_d;
	logic [KEY_W-1:0] dkey_q, dkey_d;
	logic [KEY_W-1:0] root_q;
	logic [1:0]       status_q, status_d;

	logic [CW-1:0]   cnt_q, cnt_d;
	logic [LVW-1:0]  end_lvl_q, end_lvl_d;
	logic [OFFW-1:0] end_off_q, end_off_d;

	logic [CW-1:0]   pos_idx_q, pos_idx_d;
	logic [LVW-1:0]  pos_lvl_q, pos_lvl_d;
	logic [OFFW-1:0] pos_off_q, pos_off_d;
	logic [CW-1:0]   orig_idx_q, orig_idx_d;
	logic [LVW-1:0]  orig_lvl_q, orig_lvl_d;
	logic [OFFW-1:0] orig_off_q, orig_off_d;

	logic [CW-1:0]   scan_idx_q, scan_idx_d;
	logic [LVW-1:0]  scan_lvl_q, scan_lvl_d;
	logic [OFFW-1:0] scan_off_q, scan_off_d;
	logic            chk_v_q, chk_v_d;
	logic [CW-1:0]   chk_idx_q, chk_idx_d;
	logic [LVW-1:0]  chk_lvl_q, chk_lvl_d;
	logic [OFFW-1:0] chk_off_q, chk_off_d;

	logic             out_valid_q, out_valid_d;
	logic [1:0]       out_status_q, out_status_d;
	logic             out_root_v_q, out_root_v_d;
	logic [KEY_W-1:0] out_root_q, out_root_d;
	logic [CW-1:0]    out_cnt_q, out_cnt_d;

	bh_req_t req;
	bh_rd_t  rd;
	bh_rd_t  chain [LEVELS+1];

	// Helpers for the tail slot and for the neighbors of the current slot.
	logic [OFFW:0]   end_span;
	logic [OFFW:0]   prev_span;
	logic [CW-1:0]   end_abs;
	logic [OFFW:0]   scan_span;
	logic [CW-1:0]   par_idx;
	logic [CW:0]     lch_idx;
	logic [CW:0]     rch_idx;
	logic            scan_hit;
	logic            scan_issue;
	logic            go_left;
	logic            go_right;
	logic [KEY_W-1:0] best_key;
	logic [CW+6:0]   cnt_ext;

	assign end_span  = ({{OFFW{1'b0}}, 1'b1} << end_lvl_q) - 1'b1;
	assign prev_span = ({{OFFW{1'b0}}, 1'b1} << (end_lvl_q - 1'b1)) - 1'b1;
	assign end_abs   = CW'(end_span + {1'b0, end_off_q});
	assign scan_span = ({{OFFW{1'b0}}, 1'b1} << scan_lvl_q) - 1'b1;
	assign par_idx   = (pos_idx_q - 1'b1) >> 1;
	assign lch_idx   = {pos_idx_q, 1'b1};
	assign rch_idx   = {pos_idx_q, 1'b0} + 1'b1 + 1'b1;

	assign scan_hit   = chk_v_q && (rd.a == key_q);
	assign scan_issue = !scan_hit && (scan_idx_q < cnt_q);
	assign go_left    = bh_above(rd.a, key_q, min_mode_q);
	assign best_key   = go_left ? rd.a : key_q;
	assign go_right   = (rch_idx < {1'b0, cnt_q}) && bh_above(rd.b, best_key, min_mode_q);

	always_comb begin
		state_d      = state_q;
		del_d        = del_q;
		key_d        = key_q;
		dkey_d       = dkey_q;
		status_d     = status_q;
		cnt_d        = cnt_q;
		end_lvl_d    = end_lvl_q;
		end_off_d    = end_off_q;
		pos_idx_d    = pos_idx_q;
		pos_lvl_d    = pos_lvl_q;
		pos_off_d    = pos_off_q;
		orig_idx_d   = orig_idx_q;
		orig_lvl_d   = orig_lvl_q;
		orig_off_d   = orig_off_q;
		scan_idx_d   = scan_idx_q;
		scan_lvl_d   = scan_lvl_q;
		scan_off_d   = scan_off_q;
		chk_v_d      = 1'b0;
		chk_idx_d    = chk_idx_q;
		chk_lvl_d    = chk_lvl_q;
		chk_off_d    = chk_off_q;
		out_valid_d  = out_valid_q && !out_ready;
		out_status_d = out_status_q;
		out_root_v_d = out_root_v_q;
		out_root_d   = out_root_q;
		out_cnt_d    = out_cnt_q;
		req          = '0;
		req.wr_lvl   = LVL_W'(pos_lvl_q);
		req.wr_off   = OFF_W'(pos_off_q);

		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					key_d    = key_value;
					dkey_d   = key_value;
					status_d = ST_OK;
					if (command == CMD_INSERT) begin
						del_d = 1'b0;
						if (cnt_q == CW'(HEAP_DEPTH)) begin
							status_d = ST_FULL;
							state_d  = S_FIN;
						end else begin
							pos_idx_d  = cnt_q;
							pos_lvl_d  = end_lvl_q;
							pos_off_d  = end_off_q;
							orig_idx_d = cnt_q;
							orig_lvl_d = end_lvl_q;
							orig_off_d = end_off_q;
							cnt_d      = cnt_q + 1'b1;
							if ({1'b0, end_off_q} == end_span) begin
								end_lvl_d = end_lvl_q + 1'b1;
								end_off_d = '0;
							end else begin
								end_off_d = end_off_q + 1'b1;
							end
							state_d = S_UP;
						end
					end else begin
						del_d = 1'b1;
						if (cnt_q == '0) begin
							status_d = ST_NOT_FOUND;
							state_d  = S_FIN;
						end else begin
							scan_idx_d = '0;
							scan_lvl_d = '0;
							scan_off_d = '0;
							state_d    = S_SCAN;
						end
					end
				end
			end
			S_SCAN: begin
				// Reads go out each cycle until a hit or the end; the prior read's word is compared.
				if (scan_issue) begin
					req.rd_en    = 1'b1;
					req.rd_lvl   = LVL_W'(scan_lvl_q);
					req.rd_off_a = OFF_W'(scan_off_q);
					scan_idx_d   = scan_idx_q + 1'b1;
					if ({1'b0, scan_off_q} == scan_span) begin
						scan_lvl_d = scan_lvl_q + 1'b1;
						scan_off_d = '0;
					end else begin
						scan_off_d = scan_off_q + 1'b1;
					end
				end
				chk_v_d   = scan_issue;
				chk_idx_d = scan_idx_q;
				chk_lvl_d = scan_lvl_q;
				chk_off_d = scan_off_q;
				if (scan_hit) begin
					cnt_d     = cnt_q - 1'b1;
					pos_idx_d = chk_idx_q;
					pos_lvl_d = chk_lvl_q;
					pos_off_d = chk_off_q;
					if (end_off_q == '0) begin
						end_lvl_d = end_lvl_q - 1'b1;
						end_off_d = prev_span[OFFW-1:0];
					end else begin
						end_off_d = end_off_q - 1'b1;
					end
					if (chk_idx_q == cnt_q - 1'b1) begin
						state_d = S_FIN;
					end else begin
						state_d = S_DEL_RD;
					end
				end else if (!chk_v_q && !scan_issue) begin
					status_d = ST_NOT_FOUND;
					state_d  = S_FIN;
				end
			end
			S_DEL_RD: begin
				req.rd_en    = 1'b1;
				req.rd_lvl   = LVL_W'(end_lvl_q);
				req.rd_off_a = OFF_W'(end_off_q);
				state_d      = S_DEL_LD;
			end
			S_DEL_LD: begin
				key_d      = rd.a;
				dkey_d     = rd.a;
				orig_idx_d = pos_idx_q;
				orig_lvl_d = pos_lvl_q;
				orig_off_d = pos_off_q;
				state_d    = S_UP;
			end
			S_UP: begin
				if (pos_idx_q == '0) begin
					req.wr_en  = 1'b1;
					req.wr_key = key_q;
					if (del_q) begin
						pos_idx_d = orig_idx_q;
						pos_lvl_d = orig_lvl_q;
						pos_off_d = orig_off_q;
						key_d     = dkey_q;
						state_d   = S_DN;
					end else begin
						state_d = S_FIN;
					end
				end else begin
					req.rd_en    = 1'b1;
					req.rd_lvl   = LVL_W'(pos_lvl_q - 1'b1);
					req.rd_off_a = OFF_W'(pos_off_q >> 1);
					state_d      = S_UP_CMP;
				end
			end
			S_UP_CMP: begin
				req.wr_en = 1'b1;
				if (bh_above(key_q, rd.a, min_mode_q)) begin
					// The parent moves down into the hole; the first such word is what the
					// later downward pass starts from.
					req.wr_key = rd.a;
					if (pos_idx_q == orig_idx_q) begin
						dkey_d = rd.a;
					end
					pos_idx_d = par_idx;
					pos_lvl_d = pos_lvl_q - 1'b1;
					pos_off_d = pos_off_q >> 1;
					state_d   = S_UP;
				end else begin
					req.wr_key = key_q;
					if (del_q) begin
						pos_idx_d = orig_idx_q;
						pos_lvl_d = orig_lvl_q;
						pos_off_d = orig_off_q;
						key_d     = dkey_q;
						state_d   = S_DN;
					end else begin
						state_d = S_FIN;
					end
				end
			end
			S_DN: begin
				if (lch_idx >= {1'b0, cnt_q}) begin
					req.wr_en  = 1'b1;
					req.wr_key = key_q;
					state_d    = S_FIN;
				end else begin
					req.rd_en    = 1'b1;
					req.rd_lvl   = LVL_W'(pos_lvl_q + 1'b1);
					req.rd_off_a = OFF_W'({pos_off_q, 1'b0});
					req.rd_off_b = OFF_W'({pos_off_q, 1'b1});
					state_d      = S_DN_CMP;
				end
			end
			S_DN_CMP: begin
				req.wr_en = 1'b1;
				if (go_right) begin
					req.wr_key = rd.b;
					pos_idx_d  = rch_idx[CW-1:0];
					pos_lvl_d  = pos_lvl_q + 1'b1;
					pos_off_d  = OFFW'({pos_off_q, 1'b1});
					state_d    = S_DN;
				end else if (go_left) begin
					req.wr_key = rd.a;
					pos_idx_d  = lch_idx[CW-1:0];
					pos_lvl_d  = pos_lvl_q + 1'b1;
					pos_off_d  = OFFW'({pos_off_q, 1'b0});
					state_d    = S_DN;
				end else begin
					req.wr_key = key_q;
					state_d    = S_FIN;
				end
			end
			S_FIN: begin
				if (!out_valid_q || out_ready) begin
					out_valid_d  = 1'b1;
					out_status_d = status_q;
					out_root_v_d = (cnt_q != '0);
					out_root_d   = (cnt_q != '0) ? root_q : '0;
					out_cnt_d    = cnt_q;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			min_mode_q  <= 1'b1;
			cnt_q       <= '0;
			end_lvl_q   <= '0;
			end_off_q   <= '0;
			chk_v_q     <= 1'b0;
			out_valid_q <= 1'b0;
			del_q       <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			end_lvl_q   <= end_lvl_d;
			end_off_q   <= end_off_d;
			chk_v_q     <= chk_v_d;
			out_valid_q <= out_valid_d;
			del_q       <= del_d;
			if (cfg_wr_en) begin
				min_mode_q <= cfg_wr_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		key_q        <= key_d;
		dkey_q       <= dkey_d;
		status_q     <= status_d;
		pos_idx_q    <= pos_idx_d;
		pos_lvl_q    <= pos_lvl_d;
		pos_off_q    <= pos_off_d;
		orig_idx_q   <= orig_idx_d;
		orig_lvl_q   <= orig_lvl_d;
		orig_off_q   <= orig_off_d;
		scan_idx_q   <= scan_idx_d;
		scan_lvl_q   <= scan_lvl_d;
		scan_off_q   <= scan_off_d;
		chk_idx_q    <= chk_idx_d;
		chk_lvl_q    <= chk_lvl_d;
		chk_off_q    <= chk_off_d;
		out_status_q <= out_status_d;
		out_root_v_q <= out_root_v_d;
		out_root_q   <= out_root_d;
		out_cnt_q    <= out_cnt_d;
		// A shadow of the root slot, so the result never needs an extra read.
		if (req.wr_en && (req.wr_lvl == '0)) begin
			root_q <= req.wr_key;
		end
	end

	assign chain[LEVELS] = '0;

	generate
		for (genvar g = 0; g < LEVELS; g++) begin : g_level
			localparam int SIZE = (g == LEVELS - 1) ? HEAP_DEPTH - (2 ** g - 1) : 2 ** g;
			bh_level_cell #(
				.LEVEL (g),
				.SIZE  (SIZE)
			) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.req       (req),
				.chain_in  (chain[g+1]),
				.chain_out (chain[g])
			);
		end
	endgenerate

	assign rd = chain[0];

	assign cnt_ext     = {7'd0, out_cnt_q};
	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign root_valid  = out_root_v_q;
	assign root_value  = out_root_q;
	assign entry_count = cnt_ext[6:0];

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(HEAP_DEPTH))
		else $error("entry count above heap depth");

	a_tail_track: assert property (@(posedge clk) disable iff (!arst_n)
		end_abs == cnt_q)
		else $error("tail slot out of step with entry count");

	a_scan_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> !req.wr_en)
		else $error("write issued during search");

	a_child_level: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DN) && req.rd_en |-> (pos_lvl_q + 1'b1) < LVW'(LEVELS))
		else $error("child read beyond last level");

	a_fin_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN) && (!out_valid_q || out_ready) |=>
		out_valid && (root_valid == (out_cnt_q != '0)))
		else $error("result word not loaded on finish");

endmodule

// ===== rtl/core/bh_level_cell.sv =====
// One heap level: key storage for the level's slots that the heap depth reaches, with two registered read ports.
// Uses bh_pkg for the request and read-data structs.
module bh_level_cell import bh_pkg::*; #(
	parameter int LEVEL = 0,
	parameter int SIZE  = 1
) (
	input  logic    clk,
	input  logic    arst_n,
	input  bh_req_t req,
	input  bh_rd_t  chain_in,
	output bh_rd_t  chain_out
);

	logic             sel_q;
	logic [KEY_W-1:0] rd_a_q;
	logic [KEY_W-1:0] rd_b_q;
	logic             rd_hit;
	logic             wr_hit;

	assign rd_hit = req.rd_en && (req.rd_lvl == LVL_W'(LEVEL));
	assign wr_hit = req.wr_en && (req.wr_lvl == LVL_W'(LEVEL));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= 1'b0;
		end else begin
			sel_q <= rd_hit;
		end
	end

	generate
		if (SIZE == 1) begin : g_single
			logic [KEY_W-1:0] key_store_q;
			always_ff @(posedge clk) begin
				if (wr_hit) begin
					key_store_q <= req.wr_key;
				end
				if (rd_hit) begin
					rd_a_q <= key_store_q;
					rd_b_q <= key_store_q;
				end
			end
		end else begin : g_mem
			localparam int AW = $clog2(SIZE);
			logic [KEY_W-1:0] key_store_q [SIZE];
			always_ff @(posedge clk) begin
				if (wr_hit) begin
					key_store_q[req.wr_off[AW-1:0]] <= req.wr_key;
				end
				if (rd_hit) begin
					rd_a_q <= key_store_q[req.rd_off_a[AW-1:0]];
					rd_b_q <= key_store_q[req.rd_off_b[AW-1:0]];
				end
			end
		end
	endgenerate

	// The selected level puts its word on the chain; all others pass the neighbor's word on.
	assign chain_out = sel_q ? bh_rd_t'{a: rd_a_q, b: rd_b_q} : chain_in;

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for binary_heap_insert_delete_core: insert and delete words in both orderings.
// Holds its own heap model in a small scoreboard class and checks every result word against it.
// Depends on bh_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_top import bh_pkg::*; ();

	localparam int DEPTH = 64;
	localparam int IDLE_LIMIT = 20000;
	localparam int LONG_HOLD = 3000;
	localparam int PHASES = 8;
	localparam int PHASE_WORDS = 225;

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_wr_en;
	logic                    cfg_wr_data;
	logic                    in_valid;
	logic                    in_ready;
	logic                    command;
	logic signed [KEY_W-1:0] key_value;
	logic                    out_valid;
	logic                    out_ready;
	logic [1:0]              status;
	logic                    root_valid;
	logic signed [KEY_W-1:0] root_value;
	logic [6:0]              entry_count;

	typedef struct {
		logic [1:0]              status;
		logic                    root_valid;
		logic signed [KEY_W-1:0] root;
		logic [6:0]              count;
	} heap_result_t;

	class heap_scoreboard;
		logic signed [KEY_W-1:0] slots [DEPTH];
		int                      fill;
		bit                      min_first;
		heap_result_t            awaited_results [$];
		int                      results_seen;
		int                      mismatches;

		function new();
			fill = 0;
			min_first = 1'b1;
			results_seen = 0;
			mismatches = 0;
		endfunction

		function void set_order(bit m);
			min_first = m;
		endfunction

		function int pending();
			return awaited_results.size();
		endfunction

		function bit outranks(input logic signed [KEY_W-1:0] a,
			input logic signed [KEY_W-1:0] b);
			return min_first ? (a < b) : (a > b);
		endfunction

		function void swap_slots(int i, int j);
			logic signed [KEY_W-1:0] t;
			t = slots[i];
			slots[i] = slots[j];
			slots[j] = t;
		endfunction

		function void climb(int pos);
			int parent;
			while (pos > 0 && pos < fill) begin
				parent = (pos - 1) / 2;
				if (!outranks(slots[pos], slots[parent]))
					break;
				swap_slots(pos, parent);
				pos = parent;
			end
		endfunction

		function void sink(int pos);
			int left;
			int right;
			int best;
			while (pos < fill) begin
				left = 2 * pos + 1;
				right = left + 1;
				best = pos;
				if (left < fill && outranks(slots[left], slots[best]))
					best = left;
				if (right < fill && outranks(slots[right], slots[best]))
					best = right;
				if (best == pos)
					break;
				swap_slots(pos, best);
				pos = best;
			end
		endfunction

		// Applies an accepted command word to the heap and queues the result it must produce.
		function void note_command(logic cmd, logic signed [KEY_W-1:0] key);
			heap_result_t r;
			int pos;
			r.status = ST_OK;
			if (cmd == CMD_INSERT) begin
				if (fill >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					slots[fill] = key;
					fill++;
					climb(fill - 1);
				end
			end else begin
				pos = 0;
				while (pos < fill && slots[pos] != key)
					pos++;
				if (pos >= fill) begin
					r.status = ST_NOT_FOUND;
				end else begin
					// The last entry fills the hole and may have to move either way.
					fill--;
					slots[pos] = slots[fill];
					if (pos < fill) begin
						climb(pos);
						sink(pos);
					end
				end
			end
			r.root_valid = (fill > 0);
			r.root = (fill > 0) ? slots[0] : '0;
			r.count = 7'(fill);
			awaited_results.insert(awaited_results.size(), r);
		endfunction

		function void check_result(logic [1:0] st, logic rv, logic signed [KEY_W-1:0] root,
			logic [6:0] count);
			heap_result_t want;
			results_seen++;
			if (awaited_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word: status %0d valid %0d root %0d count %0d",
						st, rv, root, count);
				return;
			end
			want = awaited_results.pop_front();
			if (want.status !== st || want.root_valid !== rv || want.root !== root ||
				want.count !== count) begin
				mismatches++;
				if (mismatches <= 10) begin
					$write("result %0d: expected status %0d valid %0d root %0d count %0d, ",
						results_seen, want.status, want.root_valid, want.root, want.count);
					$display("got status %0d valid %0d root %0d count %0d",
						st, rv, root, count);
				end
			end
		endfunction
	endclass

	heap_scoreboard sb;
	int idle_cycles = 0;
	bit long_hold_done;

	binary_heap_insert_delete_core #(
		.HEAP_DEPTH(DEPTH)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.command    (command),
		.key_value  (key_value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.root_valid (root_valid),
		.root_value (root_value),
		.entry_count(entry_count)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			sb.note_command(command, key_value);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(status, root_valid, root_value, entry_count);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Result side: stalls whose style changes every 150 words, plus one long hold-off.
	initial begin
		int hold_left;
		int rx_style;
		out_ready = 1'b0;
		hold_left = 0;
		long_hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!long_hold_done && sb.results_seen >= 500) begin
				out_ready = 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				long_hold_done = 1'b1;
			end
			rx_style = (sb.results_seen / 150) % 3;
			if (hold_left > 0) begin
				out_ready = 1'b0;
				hold_left--;
			end else begin
				out_ready = 1'b1;
				case (rx_style)
					1: if ($urandom_range(0, 3) == 0) hold_left = $urandom_range(1, 10);
					2: if ($urandom_range(0, 1) == 0) hold_left = $urandom_range(5, 60);
					default: ;
				endcase
			end
		end
	end

	// Called just after a falling edge; returns just after the falling edge that follows acceptance.
	task automatic send_word(logic cmd, logic signed [KEY_W-1:0] key);
		in_valid = 1'b1;
		command = cmd;
		key_value = key;
		do @(posedge clk); while (!(in_valid && in_ready));
		@(negedge clk);
	endtask

	task automatic pause_input(int cycles);
		in_valid = 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	task automatic wait_all_results();
		in_valid = 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_order(bit m);
		cfg_wr_en = 1'b1;
		cfg_wr_data = m;
		sb.set_order(m);
		@(negedge clk);
		cfg_wr_en = 1'b0;
		@(negedge clk);
	endtask

	// Small keys give plenty of ties and hits for deletes; extremes show up often.
	function automatic logic signed [KEY_W-1:0] fresh_key();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 40)
			return 32'(int'($urandom_range(0, 12)) - 6);
		if (sel < 50) begin
			case ($urandom_range(0, 3))
				0: return 32'h8000_0000;
				1: return 32'h7fff_ffff;
				2: return 32'h0000_0000;
				default: return 32'hffff_ffff;
			endcase
		end
		return $urandom();
	endfunction

	function automatic logic signed [KEY_W-1:0] delete_key();
		if (sb.fill > 0 && $urandom_range(0, 99) < 65)
			return sb.slots[$urandom_range(0, sb.fill - 1)];
		return fresh_key();
	endfunction

	initial begin
		int insert_pct [PHASES];
		int burst_left;
		sb = new();
		insert_pct = '{85, 40, 70, 30, 90, 50, 60, 20};
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = 1'b1;
		in_valid = 1'b0;
		command = CMD_INSERT;
		key_value = '0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: empty delete, extremes, ties, absent keys, draining to empty.
		send_word(CMD_DELETE, 32'sd5);
		send_word(CMD_INSERT, 32'sd0);
		send_word(CMD_INSERT, 32'h7fff_ffff);
		send_word(CMD_INSERT, 32'h8000_0000);
		send_word(CMD_INSERT, -32'sd1);
		send_word(CMD_INSERT, -32'sd1);
		send_word(CMD_INSERT, 32'sd0);
		send_word(CMD_DELETE, 32'sd12345);
		send_word(CMD_DELETE, -32'sd1);
		send_word(CMD_DELETE, 32'h8000_0000);
		send_word(CMD_DELETE, 32'h7fff_ffff);
		send_word(CMD_DELETE, 32'sd0);
		send_word(CMD_DELETE, -32'sd1);
		send_word(CMD_DELETE, 32'sd0);
		send_word(CMD_INSERT, 32'sd42);
		send_word(CMD_INSERT, 32'sd3);
		send_word(CMD_INSERT, 32'sd9);
		send_word(CMD_INSERT, -32'sd4);
		// Switching the order leaves the stored array as it is.
		wait_all_results();
		write_order(1'b0);
		send_word(CMD_DELETE, 32'sd3);
		send_word(CMD_INSERT, 32'sd100);
		send_word(CMD_DELETE, 32'sd1);
		send_word(CMD_DELETE, 32'sd42);
		wait_all_results();

		for (int ph = 0; ph < PHASES; ph++) begin
			write_order(ph % 2 == 0);
			burst_left = 0;
			for (int n = 0; n < PHASE_WORDS; n++) begin
				if (burst_left == 0) begin
					if ($urandom_range(0, 2) == 0)
						pause_input($urandom_range(1, 120));
					else if ($urandom_range(0, 1) == 0)
						pause_input($urandom_range(1, 12));
					burst_left = $urandom_range(1, 24);
				end
				burst_left--;
				if ($urandom_range(0, 99) < insert_pct[ph])
					send_word(CMD_INSERT, fresh_key());
				else
					send_word(CMD_DELETE, delete_key());
			end
			wait_all_results();
		end

		repeat (120) @(negedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
